FILE: hw/rtl/deq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deq_pkg
// request codes, status codes and field widths shared by the queue and its
// checker
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int FUNC_W   = 3;
    localparam int INDEX_W  = 4;
    localparam int STATUS_W = 2;

    typedef logic [FUNC_W-1:0]   t_func;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_func FN_PUSH_FRONT = 3'd0;
    localparam t_func FN_PUSH_BACK  = 3'd1;
    localparam t_func FN_POP_FRONT  = 3'd2;
    localparam t_func FN_POP_BACK   = 3'd3;
    localparam t_func FN_PEEK_FRONT = 3'd4;
    localparam t_func FN_PEEK_BACK  = 3'd5;
    localparam t_func FN_READ_INDEX = 3'd6;
    localparam t_func FN_CLEAR      = 3'd7;

    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_MISSING = 2'd1;
    localparam t_status ST_FULL    = 2'd2;

endpackage
`default_nettype wire

FILE: hw/rtl/deq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deq_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: hw/rtl/double_ended_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue
// double-ended queue of data words in a ring buffer: push, pop and peek at
// either end, read by position from the front, clear
// a taken request passes the request stage and then the output word register
// throughput: one request per cycle unless stalled, set by the single ram read
// head and count update on acceptance; the ram read is registered inside the ram
// reset: synchronous, clears head, count and valid flags; ram is not cleared
// ----------------------------------------------------------------------------
module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int WORD_WIDTH = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [FUNC_W-1:0]            i_func,
    input  wire logic [WORD_WIDTH-1:0]        i_value,
    input  wire logic [INDEX_W-1:0]           i_index,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic      [WORD_WIDTH-1:0]        o_result_word,
    output logic      [STATUS_W-1:0]          o_status,
    output logic      [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;

    function automatic logic [AW-1:0] f_slot(input logic [AW-1:0] head,
                                             input logic [CW-1:0] offset);
        logic [CW:0] sum;
        sum = (CW+1)'(head) + {1'b0, offset};
        if (sum >= (CW+1)'(DEPTH)) begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    logic [AW-1:0]         r_head;
    logic [CW-1:0]         r_count;
    logic [AW-1:0]         n_head;
    logic [CW-1:0]         n_count;

    logic                  r_p_valid;
    logic                  r_p_use_ram;
    t_status               r_p_status;
    logic [CW-1:0]         r_p_count;

    logic                  r_out_valid;
    logic [WORD_WIDTH-1:0] r_out_word;
    t_status               r_out_status;
    logic [CW-1:0]         r_out_count;

    logic                  in_accept;
    logic                  p_advance;
    logic                  full;
    logic                  empty;
    logic                  idx_hit;
    logic [AW-1:0]         head_dec;
    logic [CW-1:0]         count_dec;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [WORD_WIDTH-1:0] ram_rdata;
    t_status               req_status;

    assign p_advance  = r_p_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_p_valid && !p_advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign full      = (r_count == CW'(DEPTH));
    assign empty     = (r_count == '0);
    assign idx_hit   = (CMPW'(i_index) < CMPW'(r_count));
    assign head_dec  = (r_head == '0) ? AW'(DEPTH - 1) : r_head - 1'b1;
    assign count_dec = r_count - 1'b1;

    always_comb begin
        n_head     = r_head;
        n_count    = r_count;
        ram_we     = 1'b0;
        ram_waddr  = r_head;
        ram_re     = 1'b0;
        ram_raddr  = r_head;
        req_status = ST_OK;
        unique case (i_func)
            FN_PUSH_FRONT: begin
                if (full) begin
                    req_status = ST_FULL;
                end else begin
                    n_head    = head_dec;
                    n_count   = r_count + 1'b1;
                    ram_we    = in_accept;
                    ram_waddr = head_dec;
                end
            end
            FN_PUSH_BACK: begin
                if (full) begin
                    req_status = ST_FULL;
                end else begin
                    n_count   = r_count + 1'b1;
                    ram_we    = in_accept;
                    ram_waddr = f_slot(r_head, r_count);
                end
            end
            FN_POP_FRONT: begin
                if (empty) begin
                    req_status = ST_MISSING;
                end else begin
                    n_head    = f_slot(r_head, CW'(1));
                    n_count   = count_dec;
                    ram_re    = in_accept;
                    ram_raddr = r_head;
                end
            end
            FN_POP_BACK: begin
                if (empty) begin
                    req_status = ST_MISSING;
                end else begin
                    n_count   = count_dec;
                    ram_re    = in_accept;
                    ram_raddr = f_slot(r_head, count_dec);
                end
            end
            FN_PEEK_FRONT: begin
                if (empty) begin
                    req_status = ST_MISSING;
                end else begin
                    ram_re    = in_accept;
                    ram_raddr = r_head;
                end
            end
            FN_PEEK_BACK: begin
                if (empty) begin
                    req_status = ST_MISSING;
                end else begin
                    ram_re    = in_accept;
                    ram_raddr = f_slot(r_head, count_dec);
                end
            end
            FN_READ_INDEX: begin
                if (!idx_hit) begin
                    req_status = ST_MISSING;
                end else begin
                    ram_re    = in_accept;
                    ram_raddr = f_slot(r_head, CW'(CMPW'(i_index)));
                end
            end
            default: begin
                n_head  = '0;
                n_count = '0;
            end
        endcase
    end

    deq_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // request stage: state update and ram access issue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_count   <= '0;
            r_p_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_head  <= n_head;
                r_count <= n_count;
            end
            if (in_accept) begin
                r_p_valid <= 1'b1;
            end else if (p_advance) begin
                r_p_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_p_use_ram <= ram_re;
            r_p_status  <= req_status;
            r_p_count   <= n_count;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (p_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_advance) begin
            r_out_word   <= r_p_use_ram ? ram_rdata : '0;
            r_out_status <= r_p_status;
            r_out_count  <= r_p_count;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_word = r_out_word;
    assign o_status      = r_out_status;
    assign o_count       = r_out_count;

endmodule
`default_nettype wire

FILE: hw/rtl/deq_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deq_chk
// port-level checks for the double-ended queue, bound to the top level
// ----------------------------------------------------------------------------
module deq_chk
    import deq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int WORD_WIDTH = 32
) (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_valid,
    input wire logic                       o_in_stall,
    input wire logic                       o_out_valid,
    input wire logic                       i_out_stall,
    input wire logic [WORD_WIDTH-1:0]      o_result_word,
    input wire logic [STATUS_W-1:0]        o_status,
    input wire logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int CW = $clog2(DEPTH + 1);

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_count <= CW'(DEPTH)))
        else $error("count beyond depth");

    a_full_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_FULL) |-> (o_count == CW'(DEPTH)))
        else $error("full status with room left");

    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_stall) |-> (o_out_valid && i_out_stall))
        else $error("input stalled with the output free");

    a_fail_zero_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_result_word == '0))
        else $error("failed request returned a word");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_result_word) && $stable(o_status)
             && $stable(o_count)))
        else $error("stalled output word changed");

endmodule

bind double_ended_queue deq_chk #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
) u_deq_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_result_word (o_result_word),
    .o_status      (o_status),
    .o_count       (o_count)
);
`default_nettype wire

FILE: bench/double_ended_queue_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// double_ended_queue_test
// self-checking bench for the double-ended queue: a directed run over the
// empty and full edges and every request, then random bursts that fill and
// drain the ring, each answer checked word by word against a local model
// ----------------------------------------------------------------------------
module double_ended_queue_test;
    import deq_pkg::*;

    localparam int DEPTH      = 16;
    localparam int WORD_WIDTH = 32;
    localparam int COUNT_W    = $clog2(DEPTH + 1);
    localparam int RANDOM_N   = 900;
    localparam int LIMIT      = 200000;

    typedef struct {
        t_func                 func;
        logic [WORD_WIDTH-1:0] value;
        logic [INDEX_W-1:0]    index;
        bit                    drain;
    } t_request;

    typedef struct {
        logic [WORD_WIDTH-1:0] word;
        t_status               status;
        logic [COUNT_W-1:0]    count;
    } t_reply;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  out_stall  = 1'b0;
    logic [FUNC_W-1:0]     req_func   = '0;
    logic [WORD_WIDTH-1:0] req_value  = '0;
    logic [INDEX_W-1:0]    req_index  = '0;
    logic                  in_stall;
    logic                  out_valid;
    logic [WORD_WIDTH-1:0] res_word;
    logic [STATUS_W-1:0]   res_status;
    logic [COUNT_W-1:0]    res_count;

    t_request request_queue[$];
    t_reply   pending_replies[$];

    logic [WORD_WIDTH-1:0] model_ring [DEPTH];
    logic [INDEX_W-1:0]    model_head = '0;
    logic [COUNT_W-1:0]    model_fill = '0;

    int accepted_count = 0;
    int checked_count  = 0;
    int cycle_count    = 0;
    int errors         = 0;

    double_ended_queue #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_func        (req_func),
        .i_value       (req_value),
        .i_index       (req_index),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_result_word (res_word),
        .o_status      (res_status),
        .o_count       (res_count)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_reply deque_reply(t_request rq);
        t_reply             r;
        logic [INDEX_W-1:0] slot;
        r.word   = '0;
        r.status = ST_OK;
        case (rq.func)
            FN_PUSH_FRONT: begin
                if (model_fill == DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    model_head = model_head - 1'b1;
                    model_ring[model_head] = rq.value;
                    model_fill = model_fill + 1'b1;
                end
            end
            FN_PUSH_BACK: begin
                if (model_fill == DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    slot = model_head + model_fill[INDEX_W-1:0];
                    model_ring[slot] = rq.value;
                    model_fill = model_fill + 1'b1;
                end
            end
            FN_POP_FRONT, FN_PEEK_FRONT: begin
                if (model_fill == 0) begin
                    r.status = ST_MISSING;
                end else begin
                    r.word = model_ring[model_head];
                    if (rq.func == FN_POP_FRONT) begin
                        model_head = model_head + 1'b1;
                        model_fill = model_fill - 1'b1;
                    end
                end
            end
            FN_POP_BACK, FN_PEEK_BACK: begin
                if (model_fill == 0) begin
                    r.status = ST_MISSING;
                end else begin
                    slot = model_head + model_fill[INDEX_W-1:0] - 1'b1;
                    r.word = model_ring[slot];
                    if (rq.func == FN_POP_BACK) begin
                        model_fill = model_fill - 1'b1;
                    end
                end
            end
            FN_READ_INDEX: begin
                if (COUNT_W'(rq.index) >= model_fill) begin
                    r.status = ST_MISSING;
                end else begin
                    slot = model_head + rq.index;
                    r.word = model_ring[slot];
                end
            end
            default: begin
                model_head = '0;
                model_fill = '0;
            end
        endcase
        r.count = model_fill;
        return r;
    endfunction

    // no idling on either side for a stretch in the middle of the run
    function automatic bit take_break(int done);
        if (done >= 400 && done < 600) begin
            return 1'b0;
        end
        return $urandom_range(99) < 30;
    endfunction

    always @(posedge i_clk) begin : driver
        bit     taken;
        bit     wait_drain;
        int     outstanding;
        t_reply want;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!(in_valid && in_stall)) begin
            taken = in_valid;
            if (taken) begin
                want = deque_reply(request_queue.pop_front());
                pending_replies.push_back(want);
                accepted_count <= accepted_count + 1;
            end
            outstanding = accepted_count - checked_count + (taken ? 1 : 0);
            wait_drain  = request_queue.size() > 0 && request_queue[0].drain && outstanding != 0;
            if (request_queue.size() > 0 && !wait_drain && !take_break(accepted_count)) begin
                in_valid  <= 1'b1;
                req_func  <= request_queue[0].func;
                req_value <= request_queue[0].value;
                req_index <= request_queue[0].index;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_reply want;
        out_stall <= take_break(accepted_count);
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_replies.size() == 0) begin
                $error("result with nothing expected: word %h status %0d count %0d",
                       res_word, res_status, res_count);
                errors++;
            end else begin
                want = pending_replies.pop_front();
                checked_count <= checked_count + 1;
                if (res_word !== want.word) begin
                    $error("result_word expected %h actual %h", want.word, res_word);
                    errors++;
                end
                if (res_status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, res_status);
                    errors++;
                end
                if (res_count !== want.count) begin
                    $error("count expected %0d actual %0d", want.count, res_count);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic add_req(t_func f, logic [WORD_WIDTH-1:0] v, logic [INDEX_W-1:0] x,
                           bit d = 1'b0);
        t_request rq;
        rq.func  = f;
        rq.value = v;
        rq.index = x;
        rq.drain = d;
        request_queue.push_back(rq);
    endtask

    initial begin : stimulus
        int    mode;
        int    pick;
        t_func f;
        logic [WORD_WIDTH-1:0] v;

        // empty queue edges, both ends, then a fill to the top
        add_req(FN_CLEAR, 32'hFFFF_FFFF, 4'hF);
        add_req(FN_POP_FRONT, '0, '0);
        add_req(FN_POP_BACK, '0, '0);
        add_req(FN_PEEK_FRONT, '0, '0);
        add_req(FN_PEEK_BACK, '0, '0);
        add_req(FN_READ_INDEX, '0, 4'd0);
        add_req(FN_PUSH_FRONT, 32'h0000_0000, '0);
        add_req(FN_PUSH_BACK, 32'hFFFF_FFFF, 4'hF);
        add_req(FN_PEEK_FRONT, '0, '0);
        add_req(FN_PEEK_BACK, '0, '0);
        add_req(FN_READ_INDEX, '0, 4'd1);
        add_req(FN_READ_INDEX, '0, 4'd2);
        for (int k = 0; k < DEPTH - 2; k++) begin
            add_req((k % 2) ? FN_PUSH_FRONT : FN_PUSH_BACK, $urandom, '0);
        end
        add_req(FN_PUSH_FRONT, $urandom, '0);
        add_req(FN_PUSH_BACK, $urandom, '0);
        add_req(FN_READ_INDEX, '0, 4'hF);
        add_req(FN_CLEAR, '0, '0);

        mode = 0;
        for (int n = 0; n < RANDOM_N; n++) begin
            if (n % 60 == 0) begin
                mode = $urandom_range(2);
            end
            pick = $urandom_range(99);
            if (pick < 3) begin
                f = FN_CLEAR;
            end else if (pick < (mode == 0 ? 65 : (mode == 1 ? 28 : 48))) begin
                f = $urandom_range(1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
            end else begin
                f = t_func'($urandom_range(FN_READ_INDEX, FN_POP_FRONT));
            end
            case ($urandom_range(9))
                0:       v = '0;
                1:       v = '1;
                default: v = $urandom;
            endcase
            add_req(f, v,
                    INDEX_W'($urandom_range(1) ? $urandom_range(15) : $urandom_range(3)),
                    n == 0 || n == 450 || n == 800);
        end

        i_rst_n <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(posedge i_clk);
        end while (request_queue.size() != 0 || in_valid || accepted_count != checked_count);
        repeat (10) @(posedge i_clk);

        if (errors == 0 && pending_replies.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: double_ended_queue.f
hw/rtl/deq_pkg.sv
hw/rtl/deq_ram.sv
hw/rtl/double_ended_queue.sv
hw/rtl/deq_chk.sv
bench/double_ended_queue_test.sv
